@@ rtl/mts_pkg.sv @@
// Package for the midpoint triangle subdivider: constants, codes and beat types.
// Used by every module in rtl; depends on nothing.
`timescale 1ns / 1ps
package mts_pkg;
	localparam int VERTEX_DEPTH = 4096;
	localparam int IDX_W = $clog2(VERTEX_DEPTH);
	localparam int CNT_W = IDX_W + 1;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_SPLIT = 2'd1;
	localparam logic [1:0] MODE_END_PASS = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_TRI = 2'd1;
	localparam logic [1:0] KIND_ACK = 2'd2;
	localparam logic [1:0] KIND_ERR = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_CORNER = 2'd1;
	localparam logic [1:0] ERR_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [11:0] corner_a;
		logic [11:0] corner_b;
		logic [11:0] corner_c;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [11:0] index_one;
		logic [11:0] index_two;
		logic [11:0] index_three;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [1:0] error_code;
		logic last;
	} out_beat_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] err;
		logic [IDX_W-1:0] ca;
		logic [IDX_W-1:0] cb;
		logic [IDX_W-1:0] cc;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} job_t;

	function automatic logic [31:0] half_sum(input logic [31:0] p, input logic [31:0] q);
		logic [32:0] s;
		s = {p[31], p} + {q[31], q};
		return s[32:1];
	endfunction
endpackage

@@ rtl/midpoint_triangle_subdivider_unit.sv @@
// Top level of the midpoint triangle subdivider.
// Connects mts_front, mts_queue and mts_back; uses mts_pkg for beat types.
//
// Input beats carry a mode: append a vertex, split a triangle into four,
// end a pass, or clear the store. Each input beat yields one to seven output
// beats; the final one has last set. Both channels use valid and stall.
// The front end checks corner indices and hands the job to a one-entry queue
// that stays full until the back end has finished, so one job is in flight.
// Append, end pass, clear and a bad corner present their beat from the output
// register after the queue register; the next input beat is taken once the
// back end's registered pop has emptied the queue. A split reads its three
// corners, then searches the N vertices added in the current pass at one
// store read per cycle, then spends a step on each midpoint, found or not,
// and on each of the four triangles. Without output stalls the scan of the
// N vertices sets the rate of splits.
// After reset the vertex count and pass start are zero and the store holds
// no valid vertices; no clearing pass is needed.
// While the receiver stalls, the output beat holds and the back end waits to
// present its next beat; the queue then stays full and the input side stalls.
`timescale 1ns / 1ps
module midpoint_triangle_subdivider_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input mts_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_stall,
	output mts_pkg::out_beat_t out_data
);
	logic q_full, q_push, q_pop;
	mts_pkg::job_t q_job, q_head;
	logic [mts_pkg::CNT_W-1:0] count;

	mts_front u_front (
		.valid(in_valid), .stall(in_stall), .data(in_data),
		.count(count), .q_full(q_full), .q_push(q_push), .q_job(q_job)
	);

	mts_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_job(q_job), .pop(q_pop),
		.full(q_full), .head(q_head)
	);

	mts_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(q_full), .job(q_head), .job_pop(q_pop),
		.count(count), .valid(out_valid), .stall(out_stall), .data(out_data)
	);
endmodule

@@ rtl/mts_front.sv @@
// Front end: accepts input beats and checks the corners of a split against the vertex count.
// Uses mts_pkg; reads the committed vertex count from the back end.
`timescale 1ns / 1ps
module mts_front (
	input logic valid,
	output logic stall,
	input mts_pkg::in_beat_t data,
	input logic [mts_pkg::CNT_W-1:0] count,
	input logic q_full,
	output logic q_push,
	output mts_pkg::job_t q_job
);
	logic bad;

	assign stall = q_full;
	assign q_push = valid && !q_full;

	always_comb begin
		bad = (data.corner_a >= count) || (data.corner_b >= count) || (data.corner_c >= count);
		q_job.mode = data.mode;
		q_job.ca = data.corner_a[mts_pkg::IDX_W-1:0];
		q_job.cb = data.corner_b[mts_pkg::IDX_W-1:0];
		q_job.cc = data.corner_c[mts_pkg::IDX_W-1:0];
		q_job.px = data.pos_x;
		q_job.py = data.pos_y;
		q_job.pz = data.pos_z;
		q_job.err = mts_pkg::ERR_NONE;
		if (data.mode == mts_pkg::MODE_SPLIT && bad) begin
			q_job.err = mts_pkg::ERR_CORNER;
		end
	end
endmodule

@@ rtl/mts_queue.sv @@
// One-entry job queue between the front and the back end.
// Uses mts_pkg for the job type.
`timescale 1ns / 1ps
module mts_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mts_pkg::job_t push_job,
	input logic pop,
	output logic full,
	output mts_pkg::job_t head
);
	logic full_q;

	assign full = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push) begin
			full_q <= 1'b1;
		end else if (pop) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			head <= push_job;
		end
	end
endmodule

@@ rtl/mts_back.sv @@
// Back end: vertex store, midpoint search sequencer and result beat generation.
// Uses mts_pkg; takes jobs from mts_queue and drives the output register.
`timescale 1ns / 1ps
module mts_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input mts_pkg::job_t job,
	output logic job_pop,
	output logic [mts_pkg::CNT_W-1:0] count,
	output logic valid,
	input logic stall,
	output mts_pkg::out_beat_t data
);
	localparam int IW = mts_pkg::IDX_W;
	localparam int CW = mts_pkg::CNT_W;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RDA = 9'b000000010,
		ST_RDB = 9'b000000100,
		ST_RDC = 9'b000001000,
		ST_MID = 9'b000010000,
		ST_SCAN = 9'b000100000,
		ST_CHECK = 9'b001000000,
		ST_EMIT = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t state_q;
	logic [31:0] mem_x [mts_pkg::VERTEX_DEPTH];
	logic [31:0] mem_y [mts_pkg::VERTEX_DEPTH];
	logic [31:0] mem_z [mts_pkg::VERTEX_DEPTH];
	logic [31:0] rd_x, rd_y, rd_z;
	logic [CW-1:0] count_q, pass_q, scan_q;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [31:0] wr_x, wr_y, wr_z;
	logic wr_en;
	logic [31:0] va_x_q, va_y_q, va_z_q, vb_x_q, vb_y_q, vb_z_q;
	logic [31:0] mx_q [3];
	logic [31:0] my_q [3];
	logic [31:0] mz_q [3];
	logic [2:0] hit_q;
	logic [IW-1:0] mi_q [3];
	logic rd_live_q;
	logic [IW-1:0] rd_idx_q;
	logic [2:0] step_q;
	logic ovalid_q;
	mts_pkg::out_beat_t obeat_q;
	logic slot_free;
	logic [1:0] need;
	logic [CW:0] need_sum;

	assign count = count_q;
	assign valid = ovalid_q;
	assign data = obeat_q;
	assign slot_free = !ovalid_q || !stall;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
			mem_z[wr_addr] <= wr_z;
		end
		rd_x <= mem_x[rd_addr];
		rd_y <= mem_y[rd_addr];
		rd_z <= mem_z[rd_addr];
	end

	always_comb begin
		need = 2'(!hit_q[0]) + 2'(!hit_q[1]) + 2'(!hit_q[2]);
		need_sum = {1'b0, count_q} + (CW+1)'(need);
		rd_addr = scan_q[IW-1:0];
		case (state_q)
			ST_IDLE: rd_addr = job.ca;
			ST_RDA: rd_addr = job.cb;
			ST_RDB: rd_addr = job.cc;
			default: rd_addr = scan_q[IW-1:0];
		endcase
		wr_en = 1'b0;
		wr_addr = count_q[IW-1:0];
		wr_x = job.px;
		wr_y = job.py;
		wr_z = job.pz;
		if (state_q == ST_IDLE && job_valid && slot_free && !job_pop
			&& job.mode == mts_pkg::MODE_APPEND
			&& count_q < CW'(mts_pkg::VERTEX_DEPTH)) begin
			wr_en = 1'b1;
		end
		if (state_q == ST_EMIT && slot_free && step_q < 3'd3 && !hit_q[step_q[1:0]]) begin
			wr_en = 1'b1;
			wr_x = mx_q[step_q[1:0]];
			wr_y = my_q[step_q[1:0]];
			wr_z = mz_q[step_q[1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic ovalid_n;
		logic pop_n;
		mts_pkg::out_beat_t beat_n;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pass_q <= '0;
			scan_q <= '0;
			ovalid_q <= 1'b0;
			obeat_q <= '0;
			rd_live_q <= 1'b0;
			step_q <= '0;
			job_pop <= 1'b0;
		end else begin
			pop_n = 1'b0;
			ovalid_n = ovalid_q && stall;
			beat_n = obeat_q;
			case (state_q)
				ST_IDLE: begin
					if (job_valid && slot_free && !job_pop) begin
						beat_n = '0;
						beat_n.last = 1'b1;
						case (job.mode)
							mts_pkg::MODE_APPEND: begin
								ovalid_n = 1'b1;
								pop_n = 1'b1;
								if (count_q >= CW'(mts_pkg::VERTEX_DEPTH)) begin
									beat_n.kind = mts_pkg::KIND_ERR;
									beat_n.error_code = mts_pkg::ERR_FULL;
								end else begin
									beat_n.kind = mts_pkg::KIND_VERTEX;
									beat_n.index_one = 12'(count_q);
									beat_n.out_x = job.px;
									beat_n.out_y = job.py;
									beat_n.out_z = job.pz;
									count_q <= count_q + 1'b1;
								end
							end
							mts_pkg::MODE_SPLIT: begin
								if (job.err != mts_pkg::ERR_NONE) begin
									ovalid_n = 1'b1;
									pop_n = 1'b1;
									beat_n.kind = mts_pkg::KIND_ERR;
									beat_n.error_code = job.err;
								end else begin
									state_q <= ST_RDA;
								end
							end
							mts_pkg::MODE_END_PASS: begin
								ovalid_n = 1'b1;
								pop_n = 1'b1;
								beat_n.kind = mts_pkg::KIND_ACK;
								pass_q <= count_q;
							end
							default: begin
								ovalid_n = 1'b1;
								pop_n = 1'b1;
								beat_n.kind = mts_pkg::KIND_ACK;
								count_q <= '0;
								pass_q <= '0;
							end
						endcase
					end
				end
				ST_RDA: begin
					va_x_q <= rd_x;
					va_y_q <= rd_y;
					va_z_q <= rd_z;
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					vb_x_q <= rd_x;
					vb_y_q <= rd_y;
					vb_z_q <= rd_z;
					mx_q[0] <= mts_pkg::half_sum(va_x_q, rd_x);
					my_q[0] <= mts_pkg::half_sum(va_y_q, rd_y);
					mz_q[0] <= mts_pkg::half_sum(va_z_q, rd_z);
					state_q <= ST_RDC;
				end
				ST_RDC: begin
					mx_q[1] <= mts_pkg::half_sum(vb_x_q, rd_x);
					my_q[1] <= mts_pkg::half_sum(vb_y_q, rd_y);
					mz_q[1] <= mts_pkg::half_sum(vb_z_q, rd_z);
					mx_q[2] <= mts_pkg::half_sum(rd_x, va_x_q);
					my_q[2] <= mts_pkg::half_sum(rd_y, va_y_q);
					mz_q[2] <= mts_pkg::half_sum(rd_z, va_z_q);
					state_q <= ST_MID;
				end
				ST_MID: begin
					hit_q <= '0;
					scan_q <= pass_q;
					rd_live_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_live_q) begin
						for (int e = 0; e < 3; e++) begin
							if (rd_x == mx_q[e] && rd_y == my_q[e] && rd_z == mz_q[e]) begin
								hit_q[e] <= 1'b1;
								mi_q[e] <= rd_idx_q;
							end
						end
					end
					if (scan_q < count_q) begin
						rd_live_q <= 1'b1;
						rd_idx_q <= scan_q[IW-1:0];
						scan_q <= scan_q + 1'b1;
					end else begin
						rd_live_q <= 1'b0;
						if (!rd_live_q) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (slot_free) begin
						if (need_sum > (CW+1)'(mts_pkg::VERTEX_DEPTH)) begin
							ovalid_n = 1'b1;
							beat_n = '0;
							beat_n.kind = mts_pkg::KIND_ERR;
							beat_n.error_code = mts_pkg::ERR_FULL;
							beat_n.last = 1'b1;
							state_q <= ST_DONE;
						end else begin
							step_q <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						beat_n = '0;
						step_q <= step_q + 1'b1;
						case (step_q)
							3'd0, 3'd1, 3'd2: begin
								if (!hit_q[step_q[1:0]]) begin
									ovalid_n = 1'b1;
									beat_n.kind = mts_pkg::KIND_VERTEX;
									beat_n.index_one = 12'(count_q);
									beat_n.out_x = mx_q[step_q[1:0]];
									beat_n.out_y = my_q[step_q[1:0]];
									beat_n.out_z = mz_q[step_q[1:0]];
									mi_q[step_q[1:0]] <= count_q[IW-1:0];
									count_q <= count_q + 1'b1;
								end
							end
							3'd3: begin
								ovalid_n = 1'b1;
								beat_n.kind = mts_pkg::KIND_TRI;
								beat_n.index_one = 12'(job.ca);
								beat_n.index_two = 12'(mi_q[0]);
								beat_n.index_three = 12'(mi_q[2]);
							end
							3'd4: begin
								ovalid_n = 1'b1;
								beat_n.kind = mts_pkg::KIND_TRI;
								beat_n.index_one = 12'(mi_q[2]);
								beat_n.index_two = 12'(mi_q[1]);
								beat_n.index_three = 12'(job.cc);
							end
							3'd5: begin
								ovalid_n = 1'b1;
								beat_n.kind = mts_pkg::KIND_TRI;
								beat_n.index_one = 12'(mi_q[0]);
								beat_n.index_two = 12'(job.cb);
								beat_n.index_three = 12'(mi_q[1]);
							end
							default: begin
								ovalid_n = 1'b1;
								beat_n.kind = mts_pkg::KIND_TRI;
								beat_n.index_one = 12'(mi_q[0]);
								beat_n.index_two = 12'(mi_q[1]);
								beat_n.index_three = 12'(mi_q[2]);
								beat_n.last = 1'b1;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				default: begin
					pop_n = 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
			ovalid_q <= ovalid_n;
			job_pop <= pop_n;
			obeat_q <= beat_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pass_q <= count_q)
		else $error("Pass start is beyond the vertex count.");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(mts_pkg::VERTEX_DEPTH))
		else $error("Vertex count exceeds the store depth.");
	assert property (@(posedge clk) disable iff (!arst_n) job_pop |-> job_valid)
		else $error("Job popped from an empty queue.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !job_pop)
		else $error("Job released during the midpoint search.");
endmodule
